// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the run encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ACRE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("run encoder assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ACRE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("run encoder assertion failed");

`endif

// ===== rtl/core/acre_pkg.sv =====
// Types and constants of the CIGAR run encoder.
`default_nettype none

package acre_pkg;

	localparam logic [1:0] OP_MATCH = 2'd0;
	localparam logic [1:0] OP_INS   = 2'd1;
	localparam logic [1:0] OP_DEL   = 2'd2;
	localparam logic [1:0] OP_MIS   = 2'd3;

	localparam logic [7:0] CODE_MAX = 8'd3;

	localparam int unsigned FIELD_W = 16;

	localparam int unsigned TOT_MATCH     = 0;
	localparam int unsigned TOT_MISMATCH  = 1;
	localparam int unsigned TOT_INSERTION = 2;
	localparam int unsigned TOT_DELETION  = 3;
	localparam int unsigned TOT_SOFTCLIP  = 4;
	localparam int unsigned TOT_REFERENCE = 5;
	localparam int unsigned TOT_QUERY     = 6;
	localparam int unsigned TOT_N         = 7;

	localparam int unsigned QUEUE_DEPTH = 3;

	typedef struct packed {
		logic [1:0]                           run_op;
		logic [FIELD_W-1:0]                   run_length;
		logic                                 final_record;
		logic                                 bad_code;
		logic [TOT_N-1:0][FIELD_W-1:0]        totals;
	} rec_t;

	// Push flags for the records that the encoder core hands to the result queue in the same cycle.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/core/alignment_cigar_run_encoder.sv =====
// A request's record goes through the input register and then the result queue before it
// shows on the output; a full result queue holds the request in the input register.
// Throughput: one move per cycle while the result queue has room; a move that closes two
// runs pushes both records, and the result queue drains one record per cycle.
// Reset (arst_n low, asynchronous) clears the input stage, run state, totals
// and result queue; the block is ready to take requests once reset is released.
`default_nettype none

`include "assert_macros.svh"

module alignment_cigar_run_encoder #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  move_code,
	input  wire logic        end_of_alignment,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       run_op,
	output logic [15:0]      run_length,
	output logic             final_record,
	output logic             bad_code,
	output logic [15:0]      match_total,
	output logic [15:0]      mismatch_total,
	output logic [15:0]      insertion_total,
	output logic [15:0]      deletion_total,
	output logic [15:0]      softclip_total,
	output logic [15:0]      reference_span,
	output logic [15:0]      query_span
);

	acre_pkg::push_t core_push;
	acre_pkg::rec_t  core_rec0;
	acre_pkg::rec_t  core_rec1;
	acre_pkg::rec_t  out_rec;
	logic            queue_room;
	logic            totals_zero;

	acre_run_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.move_code       (move_code),
		.end_of_alignment(end_of_alignment),
		.room            (queue_room),
		.push            (core_push),
		.rec0            (core_rec0),
		.rec1            (core_rec1)
	);

	acre_rec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (core_push),
		.rec0     (core_rec0),
		.rec1     (core_rec1),
		.room     (queue_room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rec  (out_rec)
	);

	assign run_op          = out_rec.run_op;
	assign run_length      = out_rec.run_length;
	assign final_record    = out_rec.final_record;
	assign bad_code        = out_rec.bad_code;
	assign match_total     = out_rec.totals[acre_pkg::TOT_MATCH];
	assign mismatch_total  = out_rec.totals[acre_pkg::TOT_MISMATCH];
	assign insertion_total = out_rec.totals[acre_pkg::TOT_INSERTION];
	assign deletion_total  = out_rec.totals[acre_pkg::TOT_DELETION];
	assign softclip_total  = out_rec.totals[acre_pkg::TOT_SOFTCLIP];
	assign reference_span  = out_rec.totals[acre_pkg::TOT_REFERENCE];
	assign query_span      = out_rec.totals[acre_pkg::TOT_QUERY];

	assign totals_zero = (out_rec.totals == '0);

	`ACRE_ASSERT_IMPL(a_bad_is_final, out_valid && bad_code, final_record && run_length == 16'd0)
	`ACRE_ASSERT_IMPL(a_totals_only_final, out_valid && !final_record, totals_zero)
	`ACRE_ASSERT_IMPL(a_push_order, core_push.second, core_push.first)
	`ACRE_ASSERT_NEXT(a_push_shows, core_push.first, out_valid)

endmodule

`default_nettype wire

// ===== rtl/core/acre_rec_queue.sv =====
// Three-entry result queue that takes up to two records per cycle.
`default_nettype none

module acre_rec_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire acre_pkg::push_t push,
	input  wire acre_pkg::rec_t  rec0,
	input  wire acre_pkg::rec_t  rec1,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output acre_pkg::rec_t       out_rec
);

	acre_pkg::rec_t mem_q [acre_pkg::QUEUE_DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] count_q;
	logic       pop;
	logic [1:0] left;
	logic [1:0] n_push;

	function automatic logic [1:0] wrap_inc(input logic [1:0] p);
		return (p == 2'(acre_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign out_valid = (count_q != 2'd0);
	assign out_rec   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign left      = count_q - {1'b0, pop};
	// Two free slots are needed for the worst case of a step.
	assign room      = (left <= 2'd1);
	assign n_push    = {1'b0, push.first} + {1'b0, push.second};

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= rec0;
		end
		if (push.second) begin
			mem_q[wrap_inc(wr_q)] <= rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 2'd0;
		end else begin
			if (push.second) begin
				wr_q <= wrap_inc(wrap_inc(wr_q));
			end else if (push.first) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			count_q <= left + n_push;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/acre_run_core.sv =====
// Input register, run tracking and totals of the CIGAR run encoder.
`default_nettype none

module acre_run_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      move_code,
	input  wire logic            end_of_alignment,
	input  wire logic            room,
	output acre_pkg::push_t      push,
	output acre_pkg::rec_t       rec0,
	output acre_pkg::rec_t       rec1
);

	typedef logic [acre_pkg::TOT_N-1:0][COUNT_WIDTH-1:0] cnt_arr_t;

	logic                   valid_s1;
	logic [7:0]             code_s1;
	logic                   last_s1;

	logic [1:0]             op_q;
	logic [COUNT_WIDTH-1:0] len_q;
	logic                   open_q;
	logic                   emitted_q;
	cnt_arr_t               cnt_q;

	logic                   consume;
	logic                   bad;
	logic [1:0]             op_in;
	logic                   close1;
	logic [1:0]             op2;
	logic [COUNT_WIDTH-1:0] len2;
	cnt_arr_t               cnt_a;
	cnt_arr_t               cnt_b;
	acre_pkg::rec_t         rec_close1;
	acre_pkg::rec_t         rec_close2;
	acre_pkg::rec_t         rec_bad;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic cnt_arr_t add_run(
		input cnt_arr_t               c,
		input logic [1:0]             op,
		input logic [COUNT_WIDTH-1:0] n,
		input logic                   clip
	);
		cnt_arr_t r;
		r = c;
		case (op)
			acre_pkg::OP_MATCH: begin
				r[acre_pkg::TOT_MATCH]     = sat_add(c[acre_pkg::TOT_MATCH], n);
				r[acre_pkg::TOT_REFERENCE] = sat_add(c[acre_pkg::TOT_REFERENCE], n);
				r[acre_pkg::TOT_QUERY]     = sat_add(c[acre_pkg::TOT_QUERY], n);
			end
			acre_pkg::OP_INS: begin
				if (clip) begin
					r[acre_pkg::TOT_SOFTCLIP] = sat_add(c[acre_pkg::TOT_SOFTCLIP], n);
				end else begin
					r[acre_pkg::TOT_INSERTION] = sat_add(c[acre_pkg::TOT_INSERTION], n);
				end
				r[acre_pkg::TOT_QUERY] = sat_add(c[acre_pkg::TOT_QUERY], n);
			end
			acre_pkg::OP_DEL: begin
				r[acre_pkg::TOT_DELETION]  = sat_add(c[acre_pkg::TOT_DELETION], n);
				r[acre_pkg::TOT_REFERENCE] = sat_add(c[acre_pkg::TOT_REFERENCE], n);
			end
			default: begin
				r[acre_pkg::TOT_MISMATCH]  = sat_add(c[acre_pkg::TOT_MISMATCH], n);
				r[acre_pkg::TOT_REFERENCE] = sat_add(c[acre_pkg::TOT_REFERENCE], n);
				r[acre_pkg::TOT_QUERY]     = sat_add(c[acre_pkg::TOT_QUERY], n);
			end
		endcase
		return r;
	endfunction

	function automatic logic [acre_pkg::FIELD_W-1:0] to_field(
		input logic [COUNT_WIDTH-1:0] x
	);
		logic [31:0] w;
		w = 32'(x);
		return w[acre_pkg::FIELD_W-1:0];
	endfunction

	function automatic acre_pkg::rec_t make_rec(
		input logic [1:0]             op,
		input logic [COUNT_WIDTH-1:0] n,
		input logic                   fin,
		input cnt_arr_t               c
	);
		acre_pkg::rec_t r;
		r              = '0;
		r.run_op       = op;
		r.run_length   = to_field(n);
		r.final_record = fin;
		if (fin) begin
			for (int i = 0; i < acre_pkg::TOT_N; i++) begin
				r.totals[i] = to_field(c[i]);
			end
		end
		return r;
	endfunction

	assign consume  = valid_s1 && room;
	assign in_ready = !valid_s1 || consume;

	assign bad    = (code_s1 > acre_pkg::CODE_MAX);
	assign op_in  = code_s1[1:0];
	assign close1 = open_q && (op_in != op_q);

	// The operation of the open run, or of the move when no run is open.
	assign op2  = open_q ? op_q : op_in;
	always_comb begin
		if (close1 || !open_q) begin
			len2 = COUNT_WIDTH'(1);
		end else begin
			len2 = sat_add(len_q, COUNT_WIDTH'(1));
		end
	end

	assign cnt_a = close1 ? add_run(cnt_q, op_q, len_q, !emitted_q) : cnt_q;
	assign cnt_b = add_run(cnt_a, close1 ? op_in : op2, len2, 1'b1);

	assign rec_close1 = make_rec(op_q, len_q, 1'b0, cnt_a);
	assign rec_close2 = make_rec(close1 ? op_in : op2, len2, 1'b1, cnt_b);

	always_comb begin
		rec_bad              = '0;
		rec_bad.final_record = 1'b1;
		rec_bad.bad_code     = 1'b1;
	end

	always_comb begin
		push = '0;
		rec0 = rec_close1;
		rec1 = rec_close2;
		if (consume) begin
			if (bad) begin
				push.first = 1'b1;
				rec0       = rec_bad;
			end else begin
				push.first  = close1 || last_s1;
				push.second = close1 && last_s1;
				if (!close1) begin
					rec0 = rec_close2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= move_code;
			last_s1 <= end_of_alignment;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			op_q      <= acre_pkg::OP_MATCH;
			len_q     <= '0;
			open_q    <= 1'b0;
			emitted_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				if (bad || last_s1) begin
					// Alignment over: clear for the next one.
					op_q      <= acre_pkg::OP_MATCH;
					len_q     <= '0;
					open_q    <= 1'b0;
					emitted_q <= 1'b0;
					cnt_q     <= '0;
				end else begin
					op_q      <= close1 ? op_in : op2;
					len_q     <= len2;
					open_q    <= 1'b1;
					emitted_q <= emitted_q || close1;
					cnt_q     <= cnt_a;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the CIGAR run encoder: directed table, long runs, random alignments.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned RANDOM_MOVES = 1600;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0]     code;
		logic           eoa;
		bit             typed;
		acre_pkg::rec_t want;
	} move_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  move_code = 8'd0;
	logic        end_of_alignment = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  run_op;
	logic [15:0] run_length;
	logic        final_record;
	logic        bad_code;
	logic [15:0] match_total;
	logic [15:0] mismatch_total;
	logic [15:0] insertion_total;
	logic [15:0] deletion_total;
	logic [15:0] softclip_total;
	logic [15:0] reference_span;
	logic [15:0] query_span;

	// Encoder state as the testbench tracks it.
	logic [1:0]  run_kind;
	logic [15:0] run_len;
	bit          run_live;
	bit          run_seen;
	logic [15:0] tally [acre_pkg::TOT_N];

	acre_pkg::rec_t expected_records [$];
	move_step_t     plan [$];
	string          total_names [acre_pkg::TOT_N] = '{"match_total", "mismatch_total",
		"insertion_total", "deletion_total", "softclip_total", "reference_span", "query_span"};

	bit          steady_source = 1'b0;
	bit          steady_sink = 1'b0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned moves_sent = 0;
	int unsigned records_checked = 0;
	int unsigned alignments_closed = 0;
	int unsigned aborts_seen = 0;

	alignment_cigar_run_encoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.move_code(move_code),
		.end_of_alignment(end_of_alignment),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.run_op(run_op),
		.run_length(run_length),
		.final_record(final_record),
		.bad_code(bad_code),
		.match_total(match_total),
		.mismatch_total(mismatch_total),
		.insertion_total(insertion_total),
		.deletion_total(deletion_total),
		.softclip_total(softclip_total),
		.reference_span(reference_span),
		.query_span(query_span)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records still expected", cycles,
				expected_records.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic void clear_encoder();
		run_kind = acre_pkg::OP_MATCH;
		run_len = '0;
		run_live = 1'b0;
		run_seen = 1'b0;
		foreach (tally[k]) tally[k] = '0;
	endfunction

	function automatic acre_pkg::rec_t abort_rec();
		acre_pkg::rec_t r;
		r = '0;
		r.final_record = 1'b1;
		r.bad_code = 1'b1;
		return r;
	endfunction

	function automatic acre_pkg::rec_t final_rec(input logic [1:0] op, input int len,
		input int m, input int x, input int ins, input int del, input int clip,
		input int rspan, input int qspan);
		acre_pkg::rec_t r;
		r = '0;
		r.run_op = op;
		r.run_length = 16'(len);
		r.final_record = 1'b1;
		r.totals[acre_pkg::TOT_MATCH] = 16'(m);
		r.totals[acre_pkg::TOT_MISMATCH] = 16'(x);
		r.totals[acre_pkg::TOT_INSERTION] = 16'(ins);
		r.totals[acre_pkg::TOT_DELETION] = 16'(del);
		r.totals[acre_pkg::TOT_SOFTCLIP] = 16'(clip);
		r.totals[acre_pkg::TOT_REFERENCE] = 16'(rspan);
		r.totals[acre_pkg::TOT_QUERY] = 16'(qspan);
		return r;
	endfunction

	// Fold the open run into the totals and build its record.
	function automatic acre_pkg::rec_t close_run(input bit last);
		acre_pkg::rec_t r;
		logic [15:0] n;
		n = run_len;
		case (run_kind)
			acre_pkg::OP_MATCH: begin
				tally[acre_pkg::TOT_MATCH] = sat_sum(tally[acre_pkg::TOT_MATCH], n);
				tally[acre_pkg::TOT_REFERENCE] = sat_sum(tally[acre_pkg::TOT_REFERENCE], n);
				tally[acre_pkg::TOT_QUERY] = sat_sum(tally[acre_pkg::TOT_QUERY], n);
			end
			acre_pkg::OP_INS: begin
				// first or last run of the alignment is a soft clip
				if (last || !run_seen)
					tally[acre_pkg::TOT_SOFTCLIP] = sat_sum(tally[acre_pkg::TOT_SOFTCLIP], n);
				else
					tally[acre_pkg::TOT_INSERTION] = sat_sum(tally[acre_pkg::TOT_INSERTION], n);
				tally[acre_pkg::TOT_QUERY] = sat_sum(tally[acre_pkg::TOT_QUERY], n);
			end
			acre_pkg::OP_DEL: begin
				tally[acre_pkg::TOT_DELETION] = sat_sum(tally[acre_pkg::TOT_DELETION], n);
				tally[acre_pkg::TOT_REFERENCE] = sat_sum(tally[acre_pkg::TOT_REFERENCE], n);
			end
			default: begin
				tally[acre_pkg::TOT_MISMATCH] = sat_sum(tally[acre_pkg::TOT_MISMATCH], n);
				tally[acre_pkg::TOT_REFERENCE] = sat_sum(tally[acre_pkg::TOT_REFERENCE], n);
				tally[acre_pkg::TOT_QUERY] = sat_sum(tally[acre_pkg::TOT_QUERY], n);
			end
		endcase
		r = '0;
		r.run_op = run_kind;
		r.run_length = n;
		r.final_record = last;
		if (last)
			for (int k = 0; k < acre_pkg::TOT_N; k++) r.totals[k] = tally[k];
		run_seen = 1'b1;
		run_live = 1'b0;
		return r;
	endfunction

	function automatic void encode_move(input logic [7:0] code, input logic eoa,
		output acre_pkg::rec_t recs [2], output int n);
		n = 0;
		if (code > acre_pkg::CODE_MAX) begin
			// end mark is ignored on a bad code
			recs[0] = abort_rec();
			n = 1;
			clear_encoder();
			return;
		end
		if (run_live && code[1:0] != run_kind) begin
			recs[n] = close_run(1'b0);
			n++;
		end
		if (run_live) begin
			if (run_len != 16'hFFFF)
				run_len++;
		end else begin
			run_kind = code[1:0];
			run_len = 16'd1;
			run_live = 1'b1;
		end
		if (eoa) begin
			recs[n] = close_run(1'b1);
			n++;
			clear_encoder();
		end
	endfunction

	function automatic int idle_before_move();
		int r;
		if (steady_source)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("record %0d %s: got %0h, want %0h", records_checked,
				name, got, want));
	endtask

	// Present one request, hold it until taken, then log what it should produce.
	task automatic send_move(input logic [7:0] code, input logic eoa, input bit typed = 1'b0,
		input acre_pkg::rec_t want = '0);
		int gap;
		int n;
		acre_pkg::rec_t recs [2];
		gap = idle_before_move();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		move_code <= code;
		end_of_alignment <= eoa;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		encode_move(code, eoa, recs, n);
		if (typed)
			expected_records.insert(expected_records.size(), want);
		else
			for (int k = 0; k < n; k++)
				expected_records.insert(expected_records.size(), recs[k]);
		moves_sent++;
	endtask

	task automatic send_run(input logic [1:0] op, input int count, input logic eoa);
		for (int k = 0; k < count; k++)
			send_move({6'd0, op}, eoa && (k == count - 1));
	endtask

	task automatic add_step(input logic [7:0] code, input logic eoa, input bit typed = 1'b0,
		input acre_pkg::rec_t want = '0);
		move_step_t s;
		s.code = code;
		s.eoa = eoa;
		s.typed = typed;
		s.want = want;
		plan.insert(plan.size(), s);
	endtask

	// Output side: stall at random, sometimes for long stretches.
	initial begin
		int r;
		wait (arst_n === 1'b1);
		forever begin
			r = $urandom_range(0, 99);
			@(posedge clk);
			if (steady_sink || r < 30) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 92) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end
		end
	end

	// Compare each record taken from the block against the oldest expectation.
	always @(negedge clk) begin
		acre_pkg::rec_t seen;
		acre_pkg::rec_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			seen.run_op = run_op;
			seen.run_length = run_length;
			seen.final_record = final_record;
			seen.bad_code = bad_code;
			seen.totals[acre_pkg::TOT_MATCH] = match_total;
			seen.totals[acre_pkg::TOT_MISMATCH] = mismatch_total;
			seen.totals[acre_pkg::TOT_INSERTION] = insertion_total;
			seen.totals[acre_pkg::TOT_DELETION] = deletion_total;
			seen.totals[acre_pkg::TOT_SOFTCLIP] = softclip_total;
			seen.totals[acre_pkg::TOT_REFERENCE] = reference_span;
			seen.totals[acre_pkg::TOT_QUERY] = query_span;
			if (expected_records.size() == 0) begin
				report_mismatch($sformatf("record %0d arrived with nothing expected",
					records_checked));
			end else begin
				want = expected_records.pop_front();
				check_field("run_op", 16'(seen.run_op), 16'(want.run_op));
				check_field("run_length", seen.run_length, want.run_length);
				check_field("final_record", 16'(seen.final_record), 16'(want.final_record));
				check_field("bad_code", 16'(seen.bad_code), 16'(want.bad_code));
				for (int k = 0; k < acre_pkg::TOT_N; k++)
					check_field(total_names[k], seen.totals[k], want.totals[k]);
				if (want.bad_code)
					aborts_seen++;
				else if (want.final_record)
					alignments_closed++;
			end
			records_checked++;
		end
	end

	initial begin
		int r;
		int len;
		int random_moves;
		logic [1:0] op;
		logic [7:0] code;

		clear_encoder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single-move alignments, bad codes, clip placement, two records per move
		add_step(8'd0, 1'b1, 1'b1, final_rec(acre_pkg::OP_MATCH, 1, 1, 0, 0, 0, 0, 1, 1));
		add_step(8'd255, 1'b0, 1'b1, abort_rec());
		add_step(8'd1, 1'b0);
		add_step(8'd1, 1'b0);
		add_step(8'd0, 1'b0);
		add_step(8'd2, 1'b0);
		add_step(8'd3, 1'b0);
		add_step(8'd1, 1'b0);
		add_step(8'd0, 1'b0);
		add_step(8'd1, 1'b1);
		add_step(8'd4, 1'b1, 1'b1, abort_rec());
		add_step(8'd2, 1'b1, 1'b1, final_rec(acre_pkg::OP_DEL, 1, 0, 0, 0, 1, 0, 1, 0));
		add_step(8'd1, 1'b1, 1'b1, final_rec(acre_pkg::OP_INS, 1, 0, 0, 0, 0, 1, 0, 1));
		add_step(8'd3, 1'b1, 1'b1, final_rec(acre_pkg::OP_MIS, 1, 0, 1, 0, 0, 0, 1, 1));
		add_step(8'd0, 1'b0);
		add_step(8'd0, 1'b0);
		add_step(8'd128, 1'b0, 1'b1, abort_rec());
		add_step(8'd2, 1'b0);
		add_step(8'd2, 1'b1, 1'b1, final_rec(acre_pkg::OP_DEL, 2, 0, 0, 0, 2, 0, 2, 0));
		add_step(8'd3, 1'b0);
		add_step(8'd1, 1'b0);
		add_step(8'd3, 1'b1);
		add_step(8'h7F, 1'b0, 1'b1, abort_rec());
		add_step(8'd1, 1'b0);
		add_step(8'd1, 1'b1);
		foreach (plan[i])
			send_move(plan[i].code, plan[i].eoa, plan[i].typed, plan[i].want);

		// long runs streamed back to back with an always ready sink
		steady_source = 1'b1;
		steady_sink = 1'b1;
		send_run(acre_pkg::OP_MATCH, 120, 1'b0);
		send_run(acre_pkg::OP_MIS, 3, 1'b0);
		send_run(acre_pkg::OP_MATCH, 40, 1'b1);
		send_run(acre_pkg::OP_INS, 30, 1'b0);
		send_run(acre_pkg::OP_MATCH, 1, 1'b0);
		send_run(acre_pkg::OP_DEL, 10, 1'b0);
		send_run(acre_pkg::OP_INS, 5, 1'b1);
		steady_sink = 1'b0;

		// random alignments, mostly well formed, some aborted or lone bad codes
		random_moves = 0;
		while (random_moves < RANDOM_MOVES) begin
			steady_source = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_move(8'($urandom_range(4, 255)), 1'($urandom_range(0, 1)));
				random_moves++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
				op = ($urandom_range(0, 3) == 0) ? acre_pkg::OP_INS : 2'($urandom_range(0, 3));
				for (int k = 0; k < len; k++) begin
					if (k > 0 && $urandom_range(0, 99) < 40)
						op = 2'($urandom_range(0, 3));
					code = {6'd0, op};
					// break a sequence now and then with a bad code
					if ($urandom_range(0, 99) < 2)
						code = 8'($urandom_range(4, 255));
					send_move(code, k == len - 1);
					random_moves++;
				end
			end
		end
		steady_source = 1'b0;
		in_valid <= 1'b0;

		while (expected_records.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_records.size() != 0)
			report_mismatch($sformatf("%0d records never arrived", expected_records.size()));

		$display("sent %0d moves: directed rows, steady long runs and random alignments; %0d records checked",
			moves_sent, records_checked);
		$display("%0d alignments closed, %0d aborted by bad move codes", alignments_closed,
			aborts_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
